// File: rtl/core/mvt_pkg.sv
// Shared types and constants of the mode vote table.
package mvt_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned TTL_W  = 31;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_OWNER = 2'd3
  } op_e;

  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EAGER = 2'd2;

  localparam logic REG_DEFAULT = 1'b0;
  localparam logic REG_TTL     = 1'b1;

  localparam logic [MODE_W-1:0] DEFAULT_RST = MODE_BAL;
  localparam logic [TTL_W-1:0]  TTL_RST     = 31'd30000;
  localparam logic [TTL_W-1:0]  PRUNE_RST   = 31'd15000;

  typedef struct packed {
    logic [ID_W-1:0]   key;
    logic [MODE_W-1:0] level;
    logic [TIME_W-1:0] expiry;
  } vote_ent_t;

  typedef struct packed {
    logic              match_found;
    logic              free_found;
    logic              any_all;
    logic [MODE_W-1:0] best_all;
    logic              any_ex;
    logic [MODE_W-1:0] best_ex;
  } scan_sum_t;

endpackage

// File: rtl/core/mode_vote_table_with_expiry_unit.sv
// Mode vote table with expiry: top level with sequencer, valid bits and APB registers.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_stall_o | operation, sender_id, hint_mode, owner flags
//   out     | output    | out_valid_o, out_stall_i | accepted, effective_mode, mode_changed
//   apb     | input     | psel, penable, pready  | paddr, pwdata, prdata
//
// Each transaction is accepted, then makes one memory read per entry through the single
// read port of the vote memory, whose read data is registered, and then commits. Reset
// clears the valid bits at once, so no clearing pass is needed. A stalled result holds
// the commit until the output register frees; a new transaction is taken while a
// result still waits.
module mode_vote_table_with_expiry_unit #(
  parameter int unsigned MAX_VOTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       operation_i,
  input  logic [mvt_pkg::ID_W-1:0]         sender_id_i,
  input  logic [mvt_pkg::MODE_W-1:0]       hint_mode_i,
  input  logic                             had_owner_i,
  input  logic                             has_new_owner_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             accepted_o,
  output logic [mvt_pkg::MODE_W-1:0]       effective_mode_o,
  output logic                             mode_changed_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mvt_pkg::ADDR_W-1:0]       paddr,
  input  logic [mvt_pkg::DATA_W-1:0]       pwdata,
  output logic [mvt_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import mvt_pkg::*;

  localparam int unsigned IdxW = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1;
  localparam int unsigned CntW = $clog2(MAX_VOTES + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_VOTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Configuration and time state.
  logic [MODE_W-1:0] default_q;
  logic [TTL_W-1:0]  ttl_q;
  logic [TIME_W-1:0] now_q;
  logic [TTL_W-1:0]  cd_q;
  logic [MODE_W-1:0] last_rep_q;
  logic [TTL_W-1:0]  ttl_eff;
  logic [TTL_W-1:0]  period;
  logic [TIME_W:0]   exp_sum;
  logic              cfg_wr;

  // Transaction registers.
  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [MODE_W-1:0] lvl_q;
  logic              own_act_q;
  logic [TIME_W-1:0] exp_q;
  logic              tick_eval_q;

  // Scan control.
  logic [CntW-1:0]   cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              re;
  logic              in_acc;
  vote_ent_t         rd_ent;
  vote_ent_t         wr_ent;
  scan_sum_t         sum;
  logic [IdxW-1:0]   match_idx;
  logic [IdxW-1:0]   free_idx;
  logic              ent_expired;

  logic              valid_q [MAX_VOTES];
  logic              valid_d [MAX_VOTES];
  logic              expired_q [MAX_VOTES];

  // Commit decision.
  logic              commit;
  logic              is_set, set_ok, remove, eval;
  logic              new_live;
  logic [IdxW-1:0]   set_slot;
  logic              any_live;
  logic [MODE_W-1:0] best_live;
  logic [MODE_W-1:0] eff_mode;
  logic              acc_val;

  logic              out_valid_q;
  logic              accepted_q;
  logic [MODE_W-1:0] eff_q;
  logic              chg_q;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_DEFAULT: prdata = DATA_W'(default_q);
      REG_TTL:     prdata = DATA_W'(ttl_q);
      default:     prdata = '0;
    endcase
  end

  assign ttl_eff = (ttl_q == '0) ? TTL_W'(1) : ttl_q;
  assign period  = ((ttl_eff >> 1) == '0) ? TTL_W'(1) : (ttl_eff >> 1);
  assign exp_sum = {1'b0, now_q} + (TIME_W + 1)'(ttl_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= DEFAULT_RST;
      ttl_q     <= TTL_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DEFAULT: default_q <= (pwdata[1:0] > MODE_EAGER) ? MODE_EAGER : pwdata[1:0];
        REG_TTL:     ttl_q     <= pwdata[TTL_W-1:0];
        default:     ttl_q     <= ttl_q;
      endcase
    end
  end

  assign re = (state_q == ST_SCAN) && (cnt_q != LastCnt);

  mvt_vote_ram #(
    .Depth (MAX_VOTES),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit && set_ok),
    .waddr_i (set_slot),
    .wdata_i (wr_ent),
    .re_i    (re),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd_ent)
  );

  mvt_vote_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (in_acc),
    .en_i        (rd_vld_q),
    .ent_valid_i (valid_q[rd_idx_q]),
    .ent_i       (rd_ent),
    .idx_i       (rd_idx_q),
    .key_i       (id_q),
    .now_i       (now_q),
    .sum_o       (sum),
    .match_idx_o (match_idx),
    .free_idx_o  (free_idx),
    .expired_o   (ent_expired)
  );

  assign wr_ent.key    = id_q;
  assign wr_ent.level  = lvl_q;
  assign wr_ent.expiry = exp_q;

  assign commit   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign is_set   = (op_q == OP_SET) && (id_q != '0);
  assign set_ok   = is_set && (sum.match_found || sum.free_found);
  assign set_slot = sum.match_found ? match_idx : free_idx;
  assign new_live = exp_q > now_q;
  assign remove   = (id_q != '0) && sum.match_found &&
                    ((op_q == OP_CLEAR) || ((op_q == OP_OWNER) && own_act_q));
  assign eval     = ((op_q == OP_TICK) && tick_eval_q) || set_ok || remove;

  always_comb begin
    any_live  = sum.any_all;
    best_live = sum.best_all;
    if (set_ok) begin
      any_live  = sum.any_ex || new_live;
      best_live = sum.best_ex;
      if (new_live && (!sum.any_ex || (lvl_q > sum.best_ex))) begin
        best_live = lvl_q;
      end
    end else if (remove) begin
      any_live  = sum.any_ex;
      best_live = sum.best_ex;
    end
    if (default_q == MODE_OFF) begin
      eff_mode = MODE_OFF;
    end else if (any_live) begin
      eff_mode = best_live;
    end else begin
      eff_mode = default_q;
    end
    case (op_q)
      OP_SET:   acc_val = set_ok;
      OP_CLEAR: acc_val = (id_q != '0);
      default:  acc_val = 1'b1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_VOTES; i++) begin
      valid_d[i] = valid_q[i];
      if (commit && eval) begin
        valid_d[i] = valid_q[i] && !expired_q[i];
      end
    end
    if (commit && set_ok) begin
      valid_d[set_slot] = new_live;
    end else if (commit && remove) begin
      valid_d[match_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VOTES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < MAX_VOTES; i++) begin
        valid_q[i] <= valid_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      expired_q[rd_idx_q] <= ent_expired;
    end
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (in_acc) begin
      op_q      <= op_e'(operation_i);
      id_q      <= sender_id_i;
      lvl_q     <= (hint_mode_i > MODE_EAGER) ? MODE_EAGER : hint_mode_i;
      own_act_q <= had_owner_i && !has_new_owner_i;
      exp_q     <= exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
    end
    if (commit) begin
      accepted_q <= acc_val;
      eff_q      <= eff_mode;
      chg_q      <= eval && (eff_mode != last_rep_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      now_q       <= '0;
      cd_q        <= PRUNE_RST;
      tick_eval_q <= 1'b0;
      last_rep_q  <= DEFAULT_RST;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= re;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q       <= '0;
            tick_eval_q <= 1'b0;
            state_q     <= ST_SCAN;
            if (op_e'(operation_i) == OP_TICK) begin
              now_q <= now_q + TIME_W'(1);
              if (cd_q <= TTL_W'(1)) begin
                cd_q        <= period;
                tick_eval_q <= 1'b1;
              end else begin
                cd_q <= cd_q - TTL_W'(1);
              end
            end
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == LastCnt) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            if (eval) begin
              last_rep_q <= eff_mode;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign effective_mode_o = eff_q;
  assign mode_changed_o   = chg_q;

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("Input was not stalled after a transaction was accepted.");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("A result appeared without a commit.");

  a_change_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_changed_o) |-> (effective_mode_o == last_rep_q))
    else $error("A reported change does not match the recorded mode.");

  a_mode_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (eff_mode != 2'd3))
    else $error("Effective mode out of range.");
`endif

endmodule

// File: rtl/core/mvt_vote_ram.sv
// Vote entry memory with one write port and one registered read port.
module mvt_vote_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  mvt_pkg::vote_ent_t  wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output mvt_pkg::vote_ent_t  rdata_o
);
  import mvt_pkg::*;

  vote_ent_t mem_q [Depth];
  vote_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mvt_vote_scan.sv
// Scan accumulator: key match, first free slot, highest live vote and expiry per entry.
module mvt_vote_scan #(
  parameter int unsigned IdxW = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic                                en_i,
  input  logic                                ent_valid_i,
  input  mvt_pkg::vote_ent_t                  ent_i,
  input  logic [IdxW-1:0]                     idx_i,
  input  logic [mvt_pkg::ID_W-1:0]            key_i,
  input  logic [mvt_pkg::TIME_W-1:0]          now_i,
  output mvt_pkg::scan_sum_t                  sum_o,
  output logic [IdxW-1:0]                     match_idx_o,
  output logic [IdxW-1:0]                     free_idx_o,
  output logic                                expired_o
);
  import mvt_pkg::*;

  scan_sum_t       sum_q, sum_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            live;
  logic            key_hit;

  assign key_hit   = ent_valid_i && (ent_i.key == key_i);
  assign live      = ent_valid_i && (ent_i.expiry > now_i);
  assign expired_o = ent_valid_i && (ent_i.expiry <= now_i);

  always_comb begin
    sum_d       = sum_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    if (clr_i) begin
      sum_d = '0;
    end else if (en_i) begin
      if (key_hit && !sum_q.match_found) begin
        sum_d.match_found = 1'b1;
        match_idx_d       = idx_i;
      end
      if (!ent_valid_i && !sum_q.free_found) begin
        sum_d.free_found = 1'b1;
        free_idx_d       = idx_i;
      end
      if (live) begin
        sum_d.any_all = 1'b1;
        if (!sum_q.any_all || (ent_i.level > sum_q.best_all)) begin
          sum_d.best_all = ent_i.level;
        end
        if (!key_hit) begin
          sum_d.any_ex = 1'b1;
          if (!sum_q.any_ex || (ent_i.level > sum_q.best_ex)) begin
            sum_d.best_ex = ent_i.level;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
  end

  assign sum_o       = sum_q;
  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

// File: tb/mode_vote_table_with_expiry_unit_test.sv
// Self-checking testbench of the mode vote table with expiry: random and directed transactions.
module mode_vote_table_with_expiry_unit_test;
  import mvt_pkg::*;

  localparam int          NUM_VOTES    = 64;
  localparam int          POOL_SIZE    = 128;
  localparam int          HOLD_CYCLES  = 800;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          PRINT_CAP    = 100;
  localparam longint      CYCLE_LIMIT  = 20_000_000;
  localparam logic [31:0] FILL_BASE    = 32'h1000_0000;

  typedef struct {
    op_e         op;
    logic [31:0] id;
    logic [1:0]  hint;
    logic        had;
    logic        has_new;
  } vote_req_t;

  typedef struct {
    logic       acc;
    logic [1:0] mode;
    logic       chg;
  } vote_resp_t;

  class vote_scoreboard;
    bit          slot_live[NUM_VOTES];
    logic [31:0] slot_key[NUM_VOTES];
    logic [1:0]  slot_level[NUM_VOTES];
    logic [47:0] slot_expiry[NUM_VOTES];
    logic [47:0] now_ms;
    logic [30:0] prune_left;
    logic [1:0]  last_mode;
    logic [1:0]  dflt_mode;
    logic [30:0] ttl;
    vote_resp_t  expected_q[$];
    int          errors;
    int          results_seen;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      now_ms     = '0;
      prune_left = PRUNE_RST;
      last_mode  = DEFAULT_RST;
      dflt_mode  = DEFAULT_RST;
      ttl        = TTL_RST;
      errors     = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [1:0] clamp_level(logic [1:0] m);
      return (m > MODE_EAGER) ? MODE_EAGER : m;
    endfunction

    function logic [30:0] live_ttl();
      return (ttl == '0) ? 31'd1 : ttl;
    endfunction

    function logic [30:0] prune_period();
      logic [30:0] h;
      h = live_ttl() >> 1;
      return (h == '0) ? 31'd1 : h;
    endfunction

    function int find_slot(logic [31:0] key);
      for (int i = 0; i < NUM_VOTES; i++) begin
        if (slot_live[i] && slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    function logic [1:0] scan_mode();
      bit         any;
      logic [1:0] best;
      any  = 1'b0;
      best = MODE_OFF;
      if (dflt_mode == MODE_OFF) return MODE_OFF;
      for (int i = 0; i < NUM_VOTES; i++) begin
        if (slot_live[i] && slot_expiry[i] > now_ms) begin
          if (!any || slot_level[i] > best) best = slot_level[i];
          any = 1'b1;
        end
      end
      return any ? best : dflt_mode;
    endfunction

    function bit reassess();
      logic [1:0] m;
      for (int i = 0; i < NUM_VOTES; i++) begin
        if (slot_live[i] && slot_expiry[i] <= now_ms) slot_live[i] = 1'b0;
      end
      m = scan_mode();
      if (m != last_mode) begin
        last_mode = m;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      case (idx)
        REG_DEFAULT: dflt_mode = clamp_level(data[1:0]);
        REG_TTL:     ttl = data[30:0];
        default: ;
      endcase
    endfunction

    function void note(vote_req_t r);
      vote_resp_t  res;
      int          slot;
      int          used;
      logic [48:0] sum;
      res.acc = 1'b1;
      res.chg = 1'b0;
      case (r.op)
        OP_TICK: begin
          now_ms = now_ms + 48'd1;
          if (prune_left <= 31'd1) begin
            prune_left = prune_period();
            res.chg = reassess();
          end else begin
            prune_left = prune_left - 31'd1;
          end
        end
        OP_SET: begin
          if (r.id == '0) begin
            res.acc = 1'b0;
          end else begin
            slot = find_slot(r.id);
            if (slot < 0) begin
              used = 0;
              for (int i = 0; i < NUM_VOTES; i++) begin
                if (slot_live[i]) used++;
                else if (slot < 0) slot = i;
              end
              if (used >= NUM_VOTES) slot = -1;
            end
            if (slot < 0) begin
              res.acc = 1'b0;
            end else begin
              sum = {1'b0, now_ms} + {18'd0, live_ttl()};
              slot_live[slot]   = 1'b1;
              slot_key[slot]    = r.id;
              slot_level[slot]  = clamp_level(r.hint);
              slot_expiry[slot] = sum[48] ? '1 : sum[47:0];
              res.chg = reassess();
            end
          end
        end
        OP_CLEAR: begin
          if (r.id == '0) begin
            res.acc = 1'b0;
          end else begin
            slot = find_slot(r.id);
            if (slot >= 0) begin
              slot_live[slot] = 1'b0;
              res.chg = reassess();
            end
          end
        end
        default: begin
          if (r.had && !r.has_new && r.id != '0) begin
            slot = find_slot(r.id);
            if (slot >= 0) begin
              slot_live[slot] = 1'b0;
              res.chg = reassess();
            end
          end
        end
      endcase
      res.mode = scan_mode();
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task check(logic acc, logic [1:0] mode, logic chg);
      vote_resp_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no transaction waiting");
        return;
      end
      want = expected_q.pop_front();
      if (acc !== want.acc) report($sformatf("accepted %b, expected %b", acc, want.acc));
      if (mode !== want.mode)
        report($sformatf("effective_mode %0d, expected %0d", mode, want.mode));
      if (chg !== want.chg) report($sformatf("mode_changed %b, expected %b", chg, want.chg));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        operation_i;
  logic [ID_W-1:0]   sender_id_i;
  logic [MODE_W-1:0] hint_mode_i;
  logic              had_owner_i;
  logic              has_new_owner_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              accepted_o;
  logic [MODE_W-1:0] effective_mode_o;
  logic              mode_changed_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  vote_scoreboard sb;
  logic [31:0]    id_pool[POOL_SIZE];
  bit             tx_busy;
  bit             hold_req;
  longint         cycle_count;

  mode_vote_table_with_expiry_unit #(
    .MAX_VOTES(NUM_VOTES)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .sender_id_i     (sender_id_i),
    .hint_mode_i     (hint_mode_i),
    .had_owner_i     (had_owner_i),
    .has_new_owner_i (has_new_owner_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .effective_mode_o(effective_mode_o),
    .mode_changed_o  (mode_changed_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("mode_vote_table_with_expiry_unit_test: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check(accepted_o, effective_mode_o, mode_changed_o);
    end
  end

  initial begin
    int r;
    int len;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(300, 1500);
        end else if (r < 55) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 97) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(4, 20);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(30, 150);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  function automatic vote_req_t mk(op_e op, logic [31:0] id, logic [1:0] hint, logic had,
                                   logic has_new);
    vote_req_t r;
    r.op      = op;
    r.id      = id;
    r.hint    = hint;
    r.had     = had;
    r.has_new = has_new;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (tx_busy || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [31:0] pick_id(int pool_n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return $urandom();
    return id_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  function automatic vote_req_t rand_req(int pool_n, int set_pct);
    vote_req_t r;
    int        pick;
    r = mk(OP_TICK, pick_id(pool_n), 2'($urandom_range(0, 3)), 1'($urandom()),
           1'($urandom()));
    pick = $urandom_range(0, 99);
    if (pick < set_pct) begin
      r.op = OP_SET;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        r.op = OP_TICK;
      end else if (pick < 75) begin
        r.op = OP_CLEAR;
      end else begin
        r.op = OP_OWNER;
        if ($urandom_range(0, 99) < 70) begin
          r.had     = 1'b1;
          r.has_new = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic send(vote_req_t r, int gap);
    in_valid_i      <= 1'b1;
    operation_i     <= r.op;
    sender_id_i     <= r.id;
    hint_mode_i     <= r.hint;
    had_owner_i     <= r.had;
    has_new_owner_i <= r.has_new;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(r);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] dflt, logic [31:0] ttl_word);
    wait_idle();
    apb_write(REG_DEFAULT, {30'($urandom()), dflt});
    apb_write(REG_TTL, ttl_word);
  endtask

  task automatic run_phase(logic [1:0] dflt, logic [31:0] ttl_word, int n, int pool_n,
                           int set_pct, bit busy, bit hold);
    configure(dflt, ttl_word);
    tx_busy  = busy;
    hold_req = hold;
    repeat (n) send(rand_req(pool_n, set_pct), gap_len());
    in_valid_i <= 1'b0;
    tx_busy = 1'b0;
  endtask

  // Fill the table, let every vote lapse without a tick prune, then try a new client.
  task automatic expired_full_table();
    logic [31:0] keys[$];
    configure(MODE_BAL, 32'd30);
    for (int i = 0; i < NUM_VOTES; i++) begin
      if (sb.slot_live[i]) keys.push_back(sb.slot_key[i]);
    end
    foreach (keys[k]) send(mk(OP_CLEAR, keys[k], MODE_OFF, 1'b0, 1'b0), gap_len());
    for (int k = 0; k < NUM_VOTES; k++) begin
      send(mk(OP_SET, FILL_BASE + k, 2'(k), 1'b0, 1'b0), gap_len());
    end
    repeat (31) send(mk(OP_TICK, $urandom(), MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, FILL_BASE + NUM_VOTES, MODE_EAGER, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, FILL_BASE + 5, MODE_EAGER, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, FILL_BASE + NUM_VOTES, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_CLEAR, FILL_BASE + 5, MODE_OFF, 1'b0, 1'b0), gap_len());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    operation_i     <= OP_TICK;
    sender_id_i     <= '0;
    hint_mode_i     <= MODE_OFF;
    had_owner_i     <= 1'b0;
    has_new_owner_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    tx_busy  = 1'b0;
    hold_req = 1'b0;
    sb = new();
    id_pool[0] = 32'd1;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h7FFF_FFFF;
    id_pool[4] = 32'h5555_5555;
    id_pool[5] = 32'hAAAA_AAAA;
    for (int k = 6; k < POOL_SIZE; k++) begin
      id_pool[k] = $urandom();
      if (id_pool[k] == '0) id_pool[k] = 32'd2;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mk(OP_TICK, 32'd0, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'd0, MODE_EAGER, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1), gap_len());
    send(mk(OP_SET, 32'd1, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'h8000_0000, MODE_BAL, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'd1, MODE_EAGER, 1'b0, 1'b0), gap_len());
    send(mk(OP_CLEAR, 32'd0, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_CLEAR, 32'h1234_5678, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_CLEAR, 32'hFFFF_FFFF, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_OWNER, 32'd1, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_OWNER, 32'd1, MODE_OFF, 1'b0, 1'b1), gap_len());
    send(mk(OP_OWNER, 32'd1, MODE_OFF, 1'b1, 1'b1), gap_len());
    send(mk(OP_OWNER, 32'd0, MODE_OFF, 1'b1, 1'b0), gap_len());
    send(mk(OP_OWNER, 32'd1, MODE_OFF, 1'b1, 1'b0), gap_len());
    send(mk(OP_OWNER, 32'd1, MODE_OFF, 1'b1, 1'b0), gap_len());
    send(mk(OP_CLEAR, 32'h8000_0000, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'h7FFF_FFFF, MODE_OFF, 1'b0, 1'b0), gap_len());
    send(mk(OP_SET, 32'h5555_5555, MODE_BAL, 1'b0, 1'b0), gap_len());
    send(mk(OP_TICK, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1), gap_len());
    in_valid_i <= 1'b0;

    run_phase(MODE_EAGER, 32'd7, 12, 8, 70, 1'b0, 1'b0);
    run_phase(MODE_BAL, 32'd5, 250, 12, 40, 1'b0, 1'b1);
    run_phase(MODE_OFF, 32'd20, 200, 24, 45, 1'b0, 1'b0);
    run_phase(2'd3, 32'd1, 200, 16, 40, 1'b1, 1'b0);
    run_phase(MODE_EAGER, 32'd0, 200, 16, 40, 1'b0, 1'b0);
    run_phase(MODE_BAL, 32'h8000_003C, 250, 100, 60, 1'b1, 1'b0);
    run_phase(MODE_EAGER, 32'hFFFF_FFFF, 300, 100, 65, 1'b0, 1'b0);
    expired_full_table();
    run_phase(MODE_BAL, 32'd8, 300, 40, 40, 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("mode_vote_table_with_expiry_unit_test: PASS");
    end else begin
      $display("mode_vote_table_with_expiry_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// File: mode_vote_table_with_expiry_unit.f
rtl/core/mvt_pkg.sv
rtl/core/mvt_vote_ram.sv
rtl/core/mvt_vote_scan.sv
rtl/core/mode_vote_table_with_expiry_unit.sv
tb/mode_vote_table_with_expiry_unit_test.sv
